@@ sv/slab_pkg.sv @@
package slab_pkg;

   localparam int unsigned CFG_BITS       = 16;
   localparam int unsigned CSR_INDEX_BITS = 3;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_BEGIN  = 3'd1,
      OP_BUS    = 3'd2,
      OP_WARN   = 3'd3,
      OP_LINK   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      MODE_OFF       = 3'd0,
      MODE_BOOTING   = 3'd1,
      MODE_NORMAL    = 3'd2,
      MODE_CONNECTED = 3'd3,
      MODE_ERROR     = 3'd4,
      MODE_BUSOFF    = 3'd5,
      MODE_WARNING   = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      BUS_STARTING = 2'd0,
      BUS_NORMAL   = 2'd1,
      BUS_TX_ERROR = 2'd2,
      BUS_OFF      = 2'd3
   } bus_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CLOCK_FAULT = 3'd0,
      CSR_LINK_DECAY  = 3'd1,
      CSR_SLOW_PERIOD = 3'd2,
      CSR_FAST_PERIOD = 3'd3,
      CSR_ALT_PERIOD  = 3'd4
   } csr_index_type;

   localparam logic [CFG_BITS-1:0] LINK_DECAY_RESET  = 16'd500;
   localparam logic [CFG_BITS-1:0] SLOW_PERIOD_RESET = 16'd1000;
   localparam logic [CFG_BITS-1:0] FAST_PERIOD_RESET = 16'd250;
   localparam logic [CFG_BITS-1:0] ALT_PERIOD_RESET  = 16'd500;

   typedef struct packed {
      logic                clock_fault;
      logic [CFG_BITS-1:0] link_decay;
      logic [CFG_BITS-1:0] slow_period;
      logic [CFG_BITS-1:0] fast_period;
      logic [CFG_BITS-1:0] alt_period;
   } cfg_type;

   typedef struct packed {
      logic     red_on;
      logic     green_on;
      mode_type display_state;
   } result_type;

   typedef struct packed {
      logic    started;
      logic    clock_fault;
      bus_type bus_status;
      logic    warning;
      logic    link_active;
   } arb_flags_type;

   function automatic logic is_blinking(input mode_type mode);
      return (mode == MODE_BOOTING) || (mode == MODE_NORMAL) ||
             (mode == MODE_ERROR) || (mode == MODE_WARNING);
   endfunction

endpackage

@@ sv/slab_arbiter.sv @@
module slab_arbiter
   import slab_pkg::*;
(
   input  arb_flags_type flags,
   output mode_type      mode
);

   // fixed precedence, highest first
   always_comb begin
      if (!flags.started) begin
         mode = MODE_OFF;
      end else if (flags.clock_fault) begin
         mode = MODE_WARNING;
      end else if (flags.bus_status == BUS_OFF) begin
         mode = MODE_BUSOFF;
      end else if (flags.bus_status == BUS_TX_ERROR) begin
         mode = MODE_ERROR;
      end else if (flags.bus_status == BUS_STARTING) begin
         mode = MODE_BOOTING;
      end else if (flags.warning) begin
         mode = MODE_WARNING;
      end else if (flags.link_active) begin
         mode = MODE_CONNECTED;
      end else begin
         mode = MODE_NORMAL;
      end
   end

endmodule

@@ sv/slab_engine.sv @@
module slab_engine
   import slab_pkg::*;
#(
   parameter int unsigned COUNTER_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [2:0]            op,
   input  logic [1:0]            value,
   input  cfg_type               cfg,
   output result_type            result
);

   localparam int unsigned CMP_BITS = (COUNTER_BITS > CFG_BITS) ? COUNTER_BITS : CFG_BITS;
   localparam logic [COUNTER_BITS-1:0] COUNT_MAX = {COUNTER_BITS{1'b1}};

   mode_type                mode_ff, mode_in;
   logic                    phase_ff, phase_in;
   logic [COUNTER_BITS-1:0] elapsed_ff, elapsed_in;
   bus_type                 bus_ff, bus_in;
   logic                    link_ff, link_in;
   logic [COUNTER_BITS-1:0] age_ff, age_in;
   logic                    warn_ff, warn_in;
   logic                    started_ff, started_in;

   arb_flags_type           flags;
   mode_type                arb_mode;
   logic                    arb_go;
   logic [CFG_BITS-1:0]     half;

   assign flags.started     = started_in;
   assign flags.clock_fault = cfg.clock_fault;
   assign flags.bus_status  = bus_in;
   assign flags.warning     = warn_in;
   assign flags.link_active = link_in;

   slab_arbiter u_arbiter (
      .flags (flags),
      .mode  (arb_mode)
   );

   always_comb begin
      started_in = started_ff;
      bus_in     = bus_ff;
      warn_in    = warn_ff;
      link_in    = link_ff;
      age_in     = age_ff;
      elapsed_in = elapsed_ff;
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      arb_go     = 1'b0;
      half       = '0;

      case (op)
         OP_TICK: begin
            elapsed_in = (elapsed_ff == COUNT_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
            age_in     = (age_ff == COUNT_MAX) ? age_ff : age_ff + 1'b1;
            if (link_ff && (CMP_BITS'(age_in) >= CMP_BITS'(cfg.link_decay))) begin
               link_in = 1'b0;
               arb_go  = 1'b1;
            end
         end
         OP_BEGIN: begin
            started_in = 1'b1;
            bus_in     = BUS_STARTING;
            arb_go     = 1'b1;
         end
         OP_BUS: begin
            bus_in = bus_type'(value);
            arb_go = 1'b1;
         end
         OP_WARN: begin
            warn_in = (value != 2'd0);
            arb_go  = 1'b1;
         end
         OP_LINK: begin
            if (value != 2'd0) begin
               link_in = 1'b1;
               age_in  = '0;
            end else begin
               link_in = 1'b0;
            end
            arb_go = 1'b1;
         end
         default: begin
         end
      endcase

      // a change of display state restarts the blink
      if (arb_go && (arb_mode != mode_ff)) begin
         mode_in    = arb_mode;
         phase_in   = 1'b0;
         elapsed_in = '0;
      end

      case (mode_in)
         MODE_BOOTING, MODE_NORMAL: half = cfg.slow_period >> 1;
         MODE_ERROR:                half = cfg.fast_period >> 1;
         MODE_WARNING:              half = cfg.alt_period >> 1;
         default:                   half = '0;
      endcase

      if ((op == OP_TICK) && is_blinking(mode_in) &&
          (CMP_BITS'(elapsed_in) >= CMP_BITS'(half))) begin
         phase_in   = ~phase_in;
         elapsed_in = '0;
      end

      result.display_state = mode_in;
      result.red_on        = 1'b0;
      result.green_on      = 1'b0;
      case (mode_in)
         MODE_BOOTING, MODE_ERROR: result.red_on = phase_in;
         MODE_NORMAL:    result.green_on = phase_in;
         MODE_CONNECTED: result.green_on = 1'b1;
         MODE_BUSOFF:    result.red_on = 1'b1;
         MODE_WARNING: begin
            result.red_on   = phase_in;
            result.green_on = ~phase_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         phase_ff   <= 1'b0;
         elapsed_ff <= '0;
         bus_ff     <= BUS_STARTING;
         link_ff    <= 1'b0;
         age_ff     <= '0;
         warn_ff    <= 1'b0;
         started_ff <= 1'b0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         bus_ff     <= bus_in;
         link_ff    <= link_in;
         age_ff     <= age_in;
         warn_ff    <= warn_in;
         started_ff <= started_in;
      end
   end

endmodule

@@ sv/status_led_arbiter_blinker_top.sv @@
// Status LED arbiter and blinker for a red/green LED pair.
//
// req channel: one event per transfer. req_op selects tick (1 ms time base),
// begin, bus status, warning flag or link flag; req_value carries the bus
// status code or the flag. Unused op codes change nothing.
// rsp channel: one transfer per event with the LED levels and display state
// as they stand after that event.
// csr channel: register writes (index 0 clock fault, 1 link decay, 2 slow,
// 3 fast, 4 alternate period); always ready, take effect at the next event.
//
// From the req transfer to rsp_valid there is one input register, then the
// state update and arbitration feed the result register. Throughput is one
// event per cycle while rsp is not stalled. A stalled rsp holds its result;
// the input register still takes one more event, and req_ready drops only
// when both stages are full. Reset (synchronous, active high) empties both
// stages, restores the register defaults and returns the display to off
// with all counters cleared.
module status_led_arbiter_blinker_top
   import slab_pkg::*;
#(
   parameter int unsigned COUNTER_BITS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_op,
   input  logic [1:0]                req_value,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_red_on,
   output logic                      rsp_green_on,
   output logic [2:0]                rsp_display_state,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   cfg_type    cfg_ff;
   logic       s1_valid_ff;
   logic [2:0] s1_op_ff;
   logic [1:0] s1_value_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result_in;
   logic       out_free;
   logic       fire;

   // advance the result register when it is empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign csr_ready = 1'b1;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_fault <= 1'b0;
         cfg_ff.link_decay  <= LINK_DECAY_RESET;
         cfg_ff.slow_period <= SLOW_PERIOD_RESET;
         cfg_ff.fast_period <= FAST_PERIOD_RESET;
         cfg_ff.alt_period  <= ALT_PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CLOCK_FAULT: cfg_ff.clock_fault <= csr_data[0];
            CSR_LINK_DECAY:  cfg_ff.link_decay  <= csr_data;
            CSR_SLOW_PERIOD: cfg_ff.slow_period <= csr_data;
            CSR_FAST_PERIOD: cfg_ff.fast_period <= csr_data;
            CSR_ALT_PERIOD:  cfg_ff.alt_period  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input stage: hold the event until the engine takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_op_ff    <= req_op;
         s1_value_ff <= req_value;
      end
   end

   slab_engine #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .op     (s1_op_ff),
      .value  (s1_value_ff),
      .cfg    (cfg_ff),
      .result (result_in)
   );

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_on        = rsp_ff.red_on;
   assign rsp_green_on      = rsp_ff.green_on;
   assign rsp_display_state = rsp_ff.display_state;

endmodule

@@ sv/slab_checker.sv @@
module slab_checker
   import slab_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_red_on,
   input logic                      rsp_green_on,
   input logic [2:0]                rsp_display_state
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_on) &&
      $stable(rsp_green_on) && $stable(rsp_display_state))
      else $error("stalled result changed");

   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_display_state == MODE_OFF) |-> !rsp_red_on && !rsp_green_on)
      else $error("LEDs lit while display is off");

   a_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_display_state == MODE_CONNECTED ||
                    rsp_display_state == MODE_BUSOFF)
      |-> (rsp_red_on != rsp_green_on) &&
          (rsp_red_on == (rsp_display_state == MODE_BUSOFF)))
      else $error("steady state shows wrong LED");

   a_warn_alt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_display_state == MODE_WARNING) |-> rsp_red_on != rsp_green_on)
      else $error("warning does not alternate the pair");

endmodule

bind status_led_arbiter_blinker_top slab_checker u_slab_checker (.*);

@@ verif/tb_top.sv @@
// Drives the LED arbiter with events, predicts the LED levels and display
// state of every event, and checks each response transfer in order.
module tb_top;
   import slab_pkg::*;

   localparam int unsigned COUNTER_BITS  = 16;
   // Slowest correct run is roughly 1.3k events, each with the longest idle
   // gap before it and the longest stall behind it; the limit allows several
   // times that.
   localparam int unsigned CYCLE_LIMIT   = 600_000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_EVENTS  = 100;
   // A long link decay, and ticks just past it, so the expiry is seen.
   localparam logic [15:0] LONG_DECAY    = 16'd60;
   localparam int unsigned LONG_TICKS    = 64;
   localparam int unsigned REPORT_LIMIT  = 10;

   // Op codes with no meaning; the block must leave its state alone.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam logic [CFG_BITS-1:0] CFG_MAX = '1;

   typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_type;

   // Expectation typed in by hand for a directed row, used instead of the
   // predicted one when pinned is set.
   typedef struct packed {
      logic       pinned;
      result_type leds;
   } pin_type;

   typedef struct {
      row_kind_type        kind;
      logic [2:0]          op;
      logic [1:0]          val;
      pin_type             check;
      csr_index_type       idx;
      logic [CFG_BITS-1:0] data;
   } script_row_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [2:0]                req_op    = '0;
   logic [1:0]                req_value = '0;

   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_red_on;
   logic                      rsp_green_on;
   logic [2:0]                rsp_display_state;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_data  = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   status_led_arbiter_blinker_top #(
      .COUNTER_BITS(COUNTER_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red_on        (rsp_red_on),
      .rsp_green_on      (rsp_green_on),
      .rsp_display_state (rsp_display_state),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // ---------------------------------------------------------------------
   // LED predictor: its own copy of the registers and the display state
   // ---------------------------------------------------------------------
   logic                    cfg_clock_fault = 1'b0;
   logic [CFG_BITS-1:0]     cfg_link_decay  = LINK_DECAY_RESET;
   logic [CFG_BITS-1:0]     cfg_slow_period = SLOW_PERIOD_RESET;
   logic [CFG_BITS-1:0]     cfg_fast_period = FAST_PERIOD_RESET;
   logic [CFG_BITS-1:0]     cfg_alt_period  = ALT_PERIOD_RESET;

   mode_type                mode_now    = MODE_OFF;
   logic                    phase_now   = 1'b0;
   logic [COUNTER_BITS-1:0] blink_count = '0;
   bus_type                 bus_now     = BUS_STARTING;
   logic                    link_on     = 1'b0;
   logic [COUNTER_BITS-1:0] link_count  = '0;
   logic                    warn_on     = 1'b0;
   logic                    is_started  = 1'b0;

   // Expectations in transfer order, and hand-typed checks for sent events.
   result_type leds_due[$];
   pin_type    pinned_q[$];

   int unsigned cycle_count    = 0;
   int unsigned events_taken   = 0;
   int unsigned ticks_taken    = 0;
   int unsigned results_seen   = 0;
   int unsigned flips          = 0;
   int unsigned error_count    = 0;
   int unsigned settings_count = 0;
   logic [7:0]  modes_seen     = '0;

   // Set to drop all idling on both sides.
   logic        calm        = 1'b0;
   int unsigned stall_left  = 0;

   // Fixed precedence: not started, clock fault, bus off, tx error,
   // starting, warning, link, then normal. A new state restarts the blink.
   task automatic rearbitrate();
      mode_type pick;
      if (!is_started)                  pick = MODE_OFF;
      else if (cfg_clock_fault)         pick = MODE_WARNING;
      else if (bus_now == BUS_OFF)      pick = MODE_BUSOFF;
      else if (bus_now == BUS_TX_ERROR) pick = MODE_ERROR;
      else if (bus_now == BUS_STARTING) pick = MODE_BOOTING;
      else if (warn_on)                 pick = MODE_WARNING;
      else if (link_on)                 pick = MODE_CONNECTED;
      else                              pick = MODE_NORMAL;
      if (pick != mode_now) begin
         mode_now    = pick;
         phase_now   = 1'b0;
         blink_count = '0;
      end
   endtask

   // Apply one event to the predictor and return the LED levels after it.
   task automatic advance_leds(input logic [2:0] op, input logic [1:0] val,
                               output result_type leds);
      logic                blinks;
      logic [CFG_BITS-1:0] half;
      blinks = 1'b1;
      half   = '0;
      case (op)
         OP_TICK: begin
            // Advance both counters, saturating, then expire, then blink.
            if (blink_count != '1) blink_count++;
            if (link_count != '1) link_count++;
            if (link_on && link_count >= cfg_link_decay) begin
               link_on = 1'b0;
               rearbitrate();
            end
            case (mode_now)
               MODE_BOOTING, MODE_NORMAL: half = cfg_slow_period >> 1;
               MODE_ERROR:                half = cfg_fast_period >> 1;
               MODE_WARNING:              half = cfg_alt_period >> 1;
               default:                   blinks = 1'b0;
            endcase
            if (blinks && blink_count >= half) begin
               phase_now   = ~phase_now;
               blink_count = '0;
               flips++;
            end
         end
         OP_BEGIN: begin
            is_started = 1'b1;
            bus_now    = BUS_STARTING;
            rearbitrate();
         end
         OP_BUS: begin
            bus_now = bus_type'(val);
            rearbitrate();
         end
         OP_WARN: begin
            warn_on = (val != 2'd0);
            rearbitrate();
         end
         OP_LINK: begin
            if (val != 2'd0) begin
               link_on    = 1'b1;
               link_count = '0;
            end else begin
               link_on = 1'b0;
            end
            rearbitrate();
         end
         default: ;
      endcase

      leds.red_on        = 1'b0;
      leds.green_on      = 1'b0;
      leds.display_state = mode_now;
      case (mode_now)
         MODE_BOOTING, MODE_ERROR: leds.red_on = phase_now;
         MODE_NORMAL:              leds.green_on = phase_now;
         MODE_CONNECTED:           leds.green_on = 1'b1;
         MODE_BUSOFF:              leds.red_on = 1'b1;
         MODE_WARNING: begin
            leds.red_on   = phase_now;
            leds.green_on = ~phase_now;
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: sample at the rising edge, before the block updates
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      result_type got;
      result_type want;
      pin_type    pin;
      if (!reset) begin
         cycle_count++;

         // Check the response first: it always belongs to an older event.
         if (rsp_valid && rsp_ready) begin
            got.red_on        = rsp_red_on;
            got.green_on      = rsp_green_on;
            got.display_state = mode_type'(rsp_display_state);
            if (leds_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("cycle %0d: response with nothing outstanding: red %0b green %0b state %0d",
                           cycle_count, got.red_on, got.green_on, got.display_state);
            end else begin
               want = leds_due.pop_front();
               results_seen++;
               modes_seen[rsp_display_state] = 1'b1;
               if (got.red_on !== want.red_on || got.green_on !== want.green_on ||
                   got.display_state !== want.display_state) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("cycle %0d: mismatch, expected red %0b green %0b state %0d, got red %0b green %0b state %0d",
                              cycle_count, want.red_on, want.green_on, want.display_state,
                              got.red_on, got.green_on, got.display_state);
               end
            end
         end

         // Register writes take effect at the next event.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CLOCK_FAULT: cfg_clock_fault = csr_data[0];
               CSR_LINK_DECAY:  cfg_link_decay  = csr_data;
               CSR_SLOW_PERIOD: cfg_slow_period = csr_data;
               CSR_FAST_PERIOD: cfg_fast_period = csr_data;
               CSR_ALT_PERIOD:  cfg_alt_period  = csr_data;
               default: ;
            endcase
         end

         // Predict every accepted event; a pinned row overrides the prediction.
         if (req_valid && req_ready) begin
            pin = pinned_q.pop_front();
            advance_leds(req_op, req_value, want);
            events_taken++;
            if (req_op == OP_TICK) ticks_taken++;
            leds_due.push_back(pin.pinned ? pin.leds : want);
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, leds_due.size());
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Idling: mostly none, sometimes a few cycles, rarely a long stretch
   // ---------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(4, 1);
      return $urandom_range(40, 10);
   endfunction

   // Raise ready between any two stalls.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = calm ? 0 : pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Drivers: change inputs at the falling edge only
   // ---------------------------------------------------------------------

   // Entered at a falling edge; returns at the falling edge after the
   // transfer with valid still high, so the next event can follow directly.
   task automatic send_event(input logic [2:0] op, input logic [1:0] val,
                             input pin_type check);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pinned_q.push_back(check);
      req_op    <= op;
      req_value <= val;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid, then keep it low across a rising edge so back-to-back writes
   // never lower and raise it in the same step.
   task automatic write_reg(input csr_index_type idx, input logic [CFG_BITS-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drain: drop the request, wait for every expected transfer, then let the
   // two-stage pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (pinned_q.size() != 0 || leds_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CFG_BITS-1:0] pick_setting();
      int unsigned         r;
      logic [CFG_BITS-1:0] v;
      r = $urandom_range(99);
      if (r < 15)      v = CFG_BITS'($urandom_range(3));   // zero and one halve to zero
      else if (r < 70) v = CFG_BITS'($urandom_range(24, 4));
      else if (r < 90) v = CFG_BITS'($urandom_range(300, 25));
      else if (r < 95) v = CFG_MAX;
      else             v = CFG_BITS'($urandom());
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Directed script rows
   // ---------------------------------------------------------------------
   function automatic script_row_type row_event(input logic [2:0] op, input logic [1:0] val);
      script_row_type row;
      row.kind  = ROW_EVENT;
      row.op    = op;
      row.val   = val;
      row.check = '0;
      row.idx   = CSR_CLOCK_FAULT;
      row.data  = '0;
      return row;
   endfunction

   function automatic script_row_type row_checked(input logic [2:0] op, input logic [1:0] val,
                                                  input logic red, input logic green,
                                                  input mode_type mode);
      script_row_type row;
      row = row_event(op, val);
      row.check.pinned             = 1'b1;
      row.check.leds.red_on        = red;
      row.check.leds.green_on      = green;
      row.check.leds.display_state = mode;
      return row;
   endfunction

   function automatic script_row_type row_write(input csr_index_type idx,
                                                input logic [CFG_BITS-1:0] data);
      script_row_type row;
      row      = row_event(OP_TICK, 2'd0);
      row.kind = ROW_WRITE;
      row.idx  = idx;
      row.data = data;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      script_row_type      script_rows[$];
      script_row_type      row;
      logic [2:0]          op;
      logic [1:0]          val;
      logic                fault;
      logic [CFG_BITS-1:0] decay;
      logic [CFG_BITS-1:0] slow;
      logic [CFG_BITS-1:0] fast;
      logic [CFG_BITS-1:0] alt;
      int unsigned         r;

      // Before begin everything shows off, whatever else arrives.
      script_rows.push_back(row_checked(OP_TICK,        2'd0, 1'b0, 1'b0, MODE_OFF));
      script_rows.push_back(row_checked(OP_SPARE_LAST,  2'd3, 1'b0, 1'b0, MODE_OFF));
      script_rows.push_back(row_checked(OP_LINK,        2'd1, 1'b0, 1'b0, MODE_OFF));
      script_rows.push_back(row_checked(OP_BUS,         BUS_OFF, 1'b0, 1'b0, MODE_OFF));
      // Begin forces the bus back to starting, then walk the precedence.
      script_rows.push_back(row_checked(OP_BEGIN,       2'd0, 1'b0, 1'b0, MODE_BOOTING));
      script_rows.push_back(row_checked(OP_BUS,         BUS_OFF, 1'b1, 1'b0, MODE_BUSOFF));
      script_rows.push_back(row_checked(OP_BUS,         BUS_TX_ERROR, 1'b0, 1'b0, MODE_ERROR));
      script_rows.push_back(row_checked(OP_BUS,         BUS_NORMAL, 1'b0, 1'b1, MODE_CONNECTED));
      script_rows.push_back(row_checked(OP_WARN,        2'd2, 1'b0, 1'b1, MODE_WARNING));
      script_rows.push_back(row_checked(OP_WARN,        2'd0, 1'b0, 1'b1, MODE_CONNECTED));
      script_rows.push_back(row_checked(OP_LINK,        2'd0, 1'b0, 1'b0, MODE_NORMAL));
      // Repeated begin drops back to booting.
      script_rows.push_back(row_checked(OP_BEGIN,       2'd3, 1'b0, 1'b0, MODE_BOOTING));
      script_rows.push_back(row_checked(OP_SPARE_FIRST, 2'd1, 1'b0, 1'b0, MODE_BOOTING));
      // Shortest timers: zero decay expires on the next tick, zero half
      // periods toggle on every tick.
      script_rows.push_back(row_write(CSR_SLOW_PERIOD, 16'd2));
      script_rows.push_back(row_write(CSR_FAST_PERIOD, 16'd3));
      script_rows.push_back(row_write(CSR_ALT_PERIOD,  16'd0));
      script_rows.push_back(row_write(CSR_LINK_DECAY,  16'd0));
      script_rows.push_back(row_event(OP_BUS,  BUS_NORMAL));
      script_rows.push_back(row_event(OP_LINK, 2'd3));
      script_rows.push_back(row_event(OP_TICK, 2'd1));
      script_rows.push_back(row_event(OP_TICK, 2'd2));
      script_rows.push_back(row_event(OP_TICK, 2'd3));
      script_rows.push_back(row_event(OP_WARN, 2'd1));
      script_rows.push_back(row_event(OP_TICK, 2'd0));
      script_rows.push_back(row_event(OP_TICK, 2'd0));
      script_rows.push_back(row_event(OP_BUS,  BUS_TX_ERROR));
      script_rows.push_back(row_event(OP_TICK, 2'd0));
      script_rows.push_back(row_event(OP_TICK, 2'd0));
      // A clock fault written now waits for the next arbitrating event.
      script_rows.push_back(row_write(CSR_CLOCK_FAULT, 16'd1));
      script_rows.push_back(row_event(OP_SPARE_FIRST, 2'd0));
      script_rows.push_back(row_event(OP_TICK, 2'd0));
      script_rows.push_back(row_event(OP_BUS,  BUS_NORMAL));

      // Hold reset, then release it at a falling edge.
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      settings_count = 2;
      foreach (script_rows[i]) begin
         row = script_rows[i];
         if (row.kind == ROW_WRITE) begin
            settle();
            write_reg(row.idx, row.data);
         end else begin
            send_event(row.op, row.val, row.check);
         end
      end

      // Random phases, each under a fresh register setting. The first two
      // pin the extremes: all widest, then all narrowest.
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         calm = ($urandom_range(3) == 0);
         if (p == 0) begin
            fault = 1'b0;
            decay = CFG_MAX;
            slow  = CFG_MAX;
            fast  = CFG_MAX;
            alt   = CFG_MAX;
         end else if (p == 1) begin
            fault = 1'b0;
            decay = '0;
            slow  = 16'd1;
            fast  = '0;
            alt   = 16'd1;
         end else begin
            fault = ($urandom_range(3) == 0);
            decay = pick_setting();
            slow  = pick_setting();
            fast  = pick_setting();
            alt   = pick_setting();
         end
         write_reg(CSR_CLOCK_FAULT, {{(CFG_BITS-1){1'b0}}, fault});
         write_reg(CSR_LINK_DECAY,  decay);
         write_reg(CSR_SLOW_PERIOD, slow);
         write_reg(CSR_FAST_PERIOD, fast);
         write_reg(CSR_ALT_PERIOD,  alt);
         settings_count++;

         // Ticks dominate so blinks and expiries happen; bias bus and
         // warning toward the values that let lower-precedence states win.
         repeat (PHASE_EVENTS) begin
            r   = $urandom_range(99);
            val = 2'($urandom_range(3));
            if (r < 50) begin
               op = OP_TICK;
            end else if (r < 54) begin
               op = OP_BEGIN;
            end else if (r < 70) begin
               op = OP_BUS;
               if ($urandom_range(1) == 1) val = BUS_NORMAL;
            end else if (r < 80) begin
               op = OP_WARN;
               if ($urandom_range(1) == 1) val = 2'd0;
            end else if (r < 95) begin
               op = OP_LINK;
            end else begin
               op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            end
            send_event(op, val, '0);
         end
      end

      // Long link decay: stay connected through the ticks below it, then
      // expire into normal. Run back to back.
      settle();
      calm = 1'b1;
      write_reg(CSR_CLOCK_FAULT, '0);
      write_reg(CSR_LINK_DECAY,  LONG_DECAY);
      write_reg(CSR_SLOW_PERIOD, CFG_MAX);
      settings_count++;
      send_event(OP_BUS,  BUS_NORMAL, '0);
      send_event(OP_WARN, 2'd0, '0);
      send_event(OP_LINK, 2'd1, '0);
      repeat (LONG_TICKS) send_event(OP_TICK, 2'd0, '0);
      calm = 1'b0;

      // Drain, then give a late stray response time to show up.
      settle();
      repeat (8) @(negedge clock);
      if (leds_due.size() != 0) begin
         error_count++;
         $display("%0d expected responses never arrived", leds_due.size());
      end

      $display("covered %0d events (%0d ticks) under %0d register settings, %0d of 7 display states",
               events_taken, ticks_taken, settings_count, $countones(modes_seen));
      $display("checked %0d responses, %0d blink flips predicted, %0d errors in %0d cycles",
               results_seen, flips, error_count, cycle_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ status_led_arbiter_blinker_top.f @@
sv/slab_pkg.sv
sv/slab_arbiter.sv
sv/slab_engine.sv
sv/status_led_arbiter_blinker_top.sv
sv/slab_checker.sv
verif/tb_top.sv
